/* rtl/swg_pkg.sv */
// shared constants, sigmoid node table and stage payload types for the gated swish block
package swg_pkg;

  // number formats
  localparam int DATA_W      = 16;
  localparam int FRAC_BITS   = 12;
  localparam int SIG_FRAC    = 15;
  localparam int SIG_W       = SIG_FRAC + 1;
  localparam int CFG_INDEX_W = 4;

  // sigmoid table layout, the table spans [-8,8) in 32 equal segments of width 0.5
  localparam int SIG_SEGMENTS   = 32;
  localparam int NODE_STRIDE    = 256 / SIG_SEGMENTS;
  localparam int SEG_BITS       = $clog2(SIG_SEGMENTS);
  localparam int HALF_NODES     = SIG_SEGMENTS / 2 + 1;
  localparam int HALF_IDX_W     = $clog2(HALF_NODES);
  localparam int U_W            = FRAC_BITS + 4;
  localparam int R_W            = U_W - SEG_BITS;
  localparam int PROD_W         = SIG_W + R_W;

  // datapath widths
  localparam int BX_W        = 2 * DATA_W;
  localparam int Z_W         = BX_W - FRAC_BITS;
  localparam int M1_W        = 2 * DATA_W - 1;
  localparam int P_W         = 2 * M1_W;
  localparam int ROUND_SHIFT = 2 * FRAC_BITS + SIG_FRAC;
  localparam int Q_W         = P_W - ROUND_SHIFT;

  localparam logic signed [Z_W-1:0] SIG_RANGE_Z = Z_W'(8 << FRAC_BITS);
  localparam logic [SIG_W-1:0]      SIG_ONE     = SIG_W'(1 << SIG_FRAC);
  localparam logic [Q_W-1:0]        MAX_POS_Q   = Q_W'((1 << (DATA_W - 1)) - 1);
  localparam logic [Q_W-1:0]        MAX_NEG_Q   = Q_W'(1 << (DATA_W - 1));
  localparam logic [DATA_W-1:0]     MAX_POS     = DATA_W'((1 << (DATA_W - 1)) - 1);
  localparam logic [DATA_W-1:0]     MIN_NEG     = DATA_W'(1 << (DATA_W - 1));

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BETA_GAIN    = CFG_INDEX_W'(0),
    REG_OUTPUT_SCALE = CFG_INDEX_W'(1)
  } swg_reg_t;

  // exp(-j/16) in Q32, stepped with rounding as the node table needs it
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;
  localparam logic [63:0] ONE_Q32      = 64'd1 << 32;
  localparam logic [63:0] HALF_NUM     = 64'd1 << 47;

  function automatic logic [63:0] exp_q32(input int unsigned steps);
    logic [63:0] e;
    e = ONE_Q32;
    for (int unsigned i = 0; i < steps; i++) begin
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return e;
  endfunction

  // denominators 1 + exp(-t) for the non-negative half of the table
  localparam logic [63:0] HALF_DEN [HALF_NODES] = '{
    ONE_Q32 + exp_q32(0 * NODE_STRIDE),  ONE_Q32 + exp_q32(1 * NODE_STRIDE),
    ONE_Q32 + exp_q32(2 * NODE_STRIDE),  ONE_Q32 + exp_q32(3 * NODE_STRIDE),
    ONE_Q32 + exp_q32(4 * NODE_STRIDE),  ONE_Q32 + exp_q32(5 * NODE_STRIDE),
    ONE_Q32 + exp_q32(6 * NODE_STRIDE),  ONE_Q32 + exp_q32(7 * NODE_STRIDE),
    ONE_Q32 + exp_q32(8 * NODE_STRIDE),  ONE_Q32 + exp_q32(9 * NODE_STRIDE),
    ONE_Q32 + exp_q32(10 * NODE_STRIDE), ONE_Q32 + exp_q32(11 * NODE_STRIDE),
    ONE_Q32 + exp_q32(12 * NODE_STRIDE), ONE_Q32 + exp_q32(13 * NODE_STRIDE),
    ONE_Q32 + exp_q32(14 * NODE_STRIDE), ONE_Q32 + exp_q32(15 * NODE_STRIDE),
    ONE_Q32 + exp_q32(16 * NODE_STRIDE)
  };

  // sigmoid at t = 0, 0.5, ... 8 in Q0.15, rounded
  localparam logic [SIG_W-1:0] HALF_NODE [HALF_NODES] = '{
    SIG_W'((HALF_NUM + HALF_DEN[0] / 2) / HALF_DEN[0]),
    SIG_W'((HALF_NUM + HALF_DEN[1] / 2) / HALF_DEN[1]),
    SIG_W'((HALF_NUM + HALF_DEN[2] / 2) / HALF_DEN[2]),
    SIG_W'((HALF_NUM + HALF_DEN[3] / 2) / HALF_DEN[3]),
    SIG_W'((HALF_NUM + HALF_DEN[4] / 2) / HALF_DEN[4]),
    SIG_W'((HALF_NUM + HALF_DEN[5] / 2) / HALF_DEN[5]),
    SIG_W'((HALF_NUM + HALF_DEN[6] / 2) / HALF_DEN[6]),
    SIG_W'((HALF_NUM + HALF_DEN[7] / 2) / HALF_DEN[7]),
    SIG_W'((HALF_NUM + HALF_DEN[8] / 2) / HALF_DEN[8]),
    SIG_W'((HALF_NUM + HALF_DEN[9] / 2) / HALF_DEN[9]),
    SIG_W'((HALF_NUM + HALF_DEN[10] / 2) / HALF_DEN[10]),
    SIG_W'((HALF_NUM + HALF_DEN[11] / 2) / HALF_DEN[11]),
    SIG_W'((HALF_NUM + HALF_DEN[12] / 2) / HALF_DEN[12]),
    SIG_W'((HALF_NUM + HALF_DEN[13] / 2) / HALF_DEN[13]),
    SIG_W'((HALF_NUM + HALF_DEN[14] / 2) / HALF_DEN[14]),
    SIG_W'((HALF_NUM + HALF_DEN[15] / 2) / HALF_DEN[15]),
    SIG_W'((HALF_NUM + HALF_DEN[16] / 2) / HALF_DEN[16])
  };

  // full-range node k (0 .. SIG_SEGMENTS), mirrored from the positive half
  function automatic logic [SIG_W-1:0] sig_node(input logic [SEG_BITS:0] k);
    logic [HALF_IDX_W-1:0] idx;
    logic [SIG_W-1:0]      val;
    if (k >= (SEG_BITS + 1)'(SIG_SEGMENTS / 2)) begin
      idx = HALF_IDX_W'(k - (SEG_BITS + 1)'(SIG_SEGMENTS / 2));
      val = HALF_NODE[idx];
    end else begin
      idx = HALF_IDX_W'((SEG_BITS + 1)'(SIG_SEGMENTS / 2) - k);
      val = SIG_ONE - HALF_NODE[idx];
    end
    return val;
  endfunction

  // stage payloads
  typedef struct packed {
    logic [M1_W-1:0] m1;
    logic            neg_ax;
    logic            last;
  } swg_carry_t;

  typedef struct packed {
    logic signed [BX_W-1:0] bx;
    swg_carry_t             carry;
  } swg_front_t;

  typedef struct packed {
    logic [SIG_W-1:0] sig;
    swg_carry_t       carry;
  } swg_sig_t;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    logic              sat;
    logic              last;
  } swg_result_t;

endpackage

/* rtl/swg_sigmoid.sv */
// three-stage piecewise-linear sigmoid: table lookup, slope multiply, round and select
module swg_sigmoid
  import swg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  swg_front_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output swg_sig_t   out_data
);

  // stage a: segment lookup
  logic signed [Z_W-1:0] z;
  logic signed [Z_W-1:0] z_off;
  logic [U_W-1:0]        u;
  logic [SEG_BITS:0]     k;
  logic [SIG_W-1:0]      n0;
  logic [SIG_W-1:0]      n1;

  logic                  va_r;
  logic [SIG_W-1:0]      a_n0_r;
  logic [SIG_W-1:0]      a_diff_r;
  logic [R_W-1:0]        a_r_r;
  logic                  a_lo_r;
  logic                  a_hi_r;
  swg_carry_t            a_carry_r;

  // stage b: slope times offset
  logic                  vb_r;
  logic [SIG_W-1:0]      b_n0_r;
  logic [PROD_W-1:0]     b_prod_r;
  logic                  b_lo_r;
  logic                  b_hi_r;
  swg_carry_t            b_carry_r;

  // stage c: rounded interpolation
  logic                  vc_r;
  swg_sig_t              c_data_r;
  logic [PROD_W-1:0]     rnd_sum;
  logic [SIG_W-1:0]      sig_nxt;

  logic ready_a;
  logic ready_b;
  logic ready_c;

  assign ready_c  = !vc_r || out_ready;
  assign ready_b  = !vb_r || ready_c;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  always_comb begin
    z     = Z_W'(in_data.bx >>> FRAC_BITS);
    z_off = z + SIG_RANGE_Z;
    u     = z_off[U_W-1:0];
    k     = {1'b0, u[U_W-1 -: SEG_BITS]};
    n0    = sig_node(k);
    n1    = sig_node((SEG_BITS + 1)'(k + 1'b1));
  end

  always_comb begin
    rnd_sum = b_prod_r + PROD_W'(1 << (R_W - 1));
    if (b_lo_r) begin
      sig_nxt = '0;
    end else if (b_hi_r) begin
      sig_nxt = SIG_ONE;
    end else begin
      sig_nxt = b_n0_r + SIG_W'(rnd_sum >> R_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_valid;
      if (ready_b) vb_r <= va_r;
      if (ready_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      a_n0_r    <= n0;
      a_diff_r  <= (n1 > n0) ? SIG_W'(n1 - n0) : '0;
      a_r_r     <= u[R_W-1:0];
      a_lo_r    <= (z < -SIG_RANGE_Z);
      a_hi_r    <= (z >= SIG_RANGE_Z);
      a_carry_r <= in_data.carry;
    end
    if (ready_b) begin
      b_n0_r    <= a_n0_r;
      b_prod_r  <= PROD_W'(a_diff_r) * PROD_W'(a_r_r);
      b_lo_r    <= a_lo_r;
      b_hi_r    <= a_hi_r;
      b_carry_r <= a_carry_r;
    end
    if (ready_c) begin
      c_data_r.sig   <= sig_nxt;
      c_data_r.carry <= b_carry_r;
    end
  end

  assign out_valid = vc_r;
  assign out_data  = c_data_r;

endmodule

/* rtl/swg_product.sv */
// three-stage product: scale times sigmoid, full product, round and saturate
module swg_product
  import swg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [DATA_W-1:0] scale,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  swg_sig_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output swg_result_t              out_data
);

  logic [DATA_W-1:0] mag_s;

  // stage d
  logic              vd_r;
  logic [M1_W-1:0]   d_m1_r;
  logic [M1_W-1:0]   d_m2_r;
  logic              d_neg_r;
  logic              d_last_r;

  // stage e
  logic              ve_r;
  logic [P_W-1:0]    e_p_r;
  logic              e_neg_r;
  logic              e_last_r;

  // stage f, output register
  logic              vf_r;
  swg_result_t       f_res_r;
  swg_result_t       res_nxt;
  logic [P_W-1:0]    rnd_sum;
  logic [Q_W-1:0]    q;

  logic ready_d;
  logic ready_e;
  logic ready_f;

  assign ready_f  = !vf_r || out_ready;
  assign ready_e  = !ve_r || ready_f;
  assign ready_d  = !vd_r || ready_e;
  assign in_ready = ready_d;

  assign mag_s = scale[DATA_W-1] ? DATA_W'(-scale) : DATA_W'(scale);

  always_comb begin
    rnd_sum      = e_p_r + (P_W'(1) << (ROUND_SHIFT - 1));
    q            = Q_W'(rnd_sum >> ROUND_SHIFT);
    res_nxt.last = e_last_r;
    if (!e_neg_r) begin
      res_nxt.sat     = (q > MAX_POS_Q);
      res_nxt.product = res_nxt.sat ? MAX_POS : q[DATA_W-1:0];
    end else begin
      res_nxt.sat     = (q > MAX_NEG_Q);
      res_nxt.product = res_nxt.sat ? MIN_NEG : DATA_W'(DATA_W'(0) - q[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (ready_d) vd_r <= in_valid;
      if (ready_e) ve_r <= vd_r;
      if (ready_f) vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d) begin
      d_m1_r   <= in_data.carry.m1;
      d_m2_r   <= M1_W'(BX_W'(mag_s) * BX_W'(in_data.sig));
      d_neg_r  <= in_data.carry.neg_ax ^ scale[DATA_W-1];
      d_last_r <= in_data.carry.last;
    end
    if (ready_e) begin
      e_p_r    <= P_W'(d_m1_r) * P_W'(d_m2_r);
      e_neg_r  <= d_neg_r;
      e_last_r <= d_last_r;
    end
    if (ready_f) begin
      f_res_r <= res_nxt;
    end
  end

  assign out_valid = vf_r;
  assign out_data  = f_res_r;

endmodule

/* rtl/swish_gated_multiply.sv */
// top level of the gated swish block: input stage, configuration registers, pipeline
// Gated swish, one result per input transfer: product_out = scale * a * x *
// sigmoid(beta * x), all values signed Q4.12, with the sigmoid from a 32-segment
// piecewise-linear table over [-8,8) in Q0.15 (0 below, 1.0 at or above). The
// product is rounded once, halves away from zero, and clipped to 16 bits;
// out_tuser flags a clipped result and out_tlast copies in_tlast. The pipeline
// has seven register stages (input multiplies, sigmoid lookup, slope multiply,
// interpolation, scale multiply, wide product, round and saturate). One transfer
// per cycle is sustained while out_tready is high, and a stalled output fills
// empty stages before in_tready drops. The widest step is the 31 x 31 magnitude
// product in its own stage. Register writes on the cfg channel are always taken
// (cfg_ready is high) and should only be made while no transfer is in flight;
// unknown indexes are ignored.
module swish_gated_multiply
  import swg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [2*DATA_W-1:0]    in_tdata,   // [15:0] gate_value, [31:16] swish_input
  input  logic                   in_tlast,   // last_element
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [DATA_W-1:0]      out_tdata,  // [15:0] product_out
  output logic                   out_tuser,  // [0] saturated
  output logic                   out_tlast,  // last_out
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  // configuration
  logic signed [DATA_W-1:0] beta_r;
  logic signed [DATA_W-1:0] scale_r;

  // input fields
  logic signed [DATA_W-1:0] gate_a;
  logic signed [DATA_W-1:0] swish_x;
  logic [DATA_W-1:0]        mag_a;
  logic [DATA_W-1:0]        mag_x;

  // stage 1 register: beta*x and |a|*|x| in parallel
  logic                     s1_valid_r;
  swg_front_t               s1_data_r;
  swg_front_t               s1_nxt;
  logic                     s1_ready;

  // between sigmoid and product sections
  logic                     sig_in_ready;
  logic                     sig_valid;
  logic                     sig_ready;
  swg_sig_t                 sig_data;
  swg_result_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r  <= DATA_W'(1 << FRAC_BITS);
      scale_r <= DATA_W'(1 << FRAC_BITS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BETA_GAIN:    beta_r  <= cfg_data;
        REG_OUTPUT_SCALE: scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gate_a  = in_tdata[DATA_W-1:0];
  assign swish_x = in_tdata[2*DATA_W-1:DATA_W];
  // magnitude of the most negative value is 2^15, still fits unsigned
  assign mag_a   = gate_a[DATA_W-1] ? DATA_W'(-gate_a) : DATA_W'(gate_a);
  assign mag_x   = swish_x[DATA_W-1] ? DATA_W'(-swish_x) : DATA_W'(swish_x);

  always_comb begin
    s1_nxt.bx           = BX_W'(beta_r) * BX_W'(swish_x);
    s1_nxt.carry.m1     = M1_W'(BX_W'(mag_a) * BX_W'(mag_x));
    s1_nxt.carry.neg_ax = gate_a[DATA_W-1] ^ swish_x[DATA_W-1];
    s1_nxt.carry.last   = in_tlast;
  end

  // stage 1 takes a transfer when empty or when it moves on this cycle
  assign s1_ready  = !s1_valid_r || sig_in_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_data_r <= s1_nxt;
    end
  end

  // sigmoid of beta*x truncated to 12 fraction bits, plus pass-through of the magnitude product
  swg_sigmoid u_sigmoid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_ready  (sig_in_ready),
    .in_data   (s1_data_r),
    .out_valid (sig_valid),
    .out_ready (sig_ready),
    .out_data  (sig_data)
  );

  // scale, full product, rounding and clipping; last stage is the output register
  swg_product u_product (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale     (scale_r),
    .in_valid  (sig_valid),
    .in_ready  (sig_ready),
    .in_data   (sig_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = res.product;
  assign out_tuser = res.sat;
  assign out_tlast = res.last;

endmodule
